FILE: hdl/bgfb_pkg.sv
// ----------------------------------------------------------------------------
// Bar graph frame builder package
// Op codes, command words, the level store request types and the helper
// functions that turn a bar level into a display byte.
// ----------------------------------------------------------------------------
package bgfb_pkg;

   // Bar store geometry.
   localparam int NumBars  = 16;
   localparam int BarIdxW  = $clog2(NumBars);
   localparam int LevelW   = 5;

   // Request field widths.
   localparam int OpW      = 3;
   localparam int AmountW  = 8;
   localparam int WordW    = 16;

   // Op codes carried in a request.
   localparam logic [OpW-1:0] OP_SET_LEVEL     = 3'd0;
   localparam logic [OpW-1:0] OP_REFRESH       = 3'd1;
   localparam logic [OpW-1:0] OP_SET_INTENSITY = 3'd2;
   localparam logic [OpW-1:0] OP_TEST_ON       = 3'd3;
   localparam logic [OpW-1:0] OP_TEST_OFF      = 3'd4;
   localparam logic [OpW-1:0] OP_INIT          = 3'd5;

   // Limits and command words.
   localparam logic [LevelW-1:0]  MAX_LEVEL     = 5'd16;
   localparam logic [AmountW-1:0] MAX_INTENSITY = 8'd15;
   localparam logic [7:0]         REG_INTENSITY = 8'h0A;
   localparam logic [WordW-1:0]   CMD_TEST_ON   = 16'h0F01;
   localparam logic [WordW-1:0]   CMD_TEST_OFF  = 16'h0F00;

   // Start-up sequence: decode mode, intensity, scan limit, shutdown off.
   localparam logic [WordW-1:0] INIT_SEQ [4] = '{16'h0900, 16'h0A0F, 16'h0B07, 16'h0C01};

   // Write request into the level store.
   typedef struct packed {
      logic              en;
      logic [BarIdxW-1:0] addr;
      logic [LevelW-1:0]  level;
   } lvl_wr_type;

   // Read request into the level store.
   typedef struct packed {
      logic              en;
      logic [BarIdxW-1:0] addr;
   } lvl_rd_type;

   // Thermometer mask of a level: the low "level" bits set.
   function automatic logic [15:0] thermo_mask(input logic [LevelW-1:0] level);
      logic [16:0] t;
      t = (17'd1 << level) - 17'd1;
      return t[15:0];
   endfunction

   // Mirror the bit order of a byte.
   function automatic logic [7:0] flip_byte(input logic [7:0] b);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = b[7-i];
      end
      return r;
   endfunction

   // Bar that feeds a word slot of a row. Slots 0 and 1 take bars 7-k and
   // 15-k, slots 2 and 3 take bars k+8 and k.
   function automatic logic [BarIdxW-1:0] slot_bar(input logic [2:0] row,
                                                   input logic [1:0] slot);
      logic [BarIdxW-1:0] a;
      unique case (slot)
         2'd0:    a = {1'b0, ~row};
         2'd1:    a = {1'b1, ~row};
         2'd2:    a = {1'b1, row};
         default: a = {1'b0, row};
      endcase
      return a;
   endfunction

   // Display byte of a slot: high byte of the mask for the first two slots,
   // the mirrored low byte for the last two.
   function automatic logic [7:0] slot_byte(input logic [1:0] slot,
                                            input logic [LevelW-1:0] level);
      logic [15:0] m;
      m = thermo_mask(level);
      return slot[1] ? flip_byte(m[7:0]) : m[15:8];
   endfunction

endpackage

FILE: hdl/bgfb_level_store.sv
// ----------------------------------------------------------------------------
// Bar level store
// Synchronous memory of bar levels with a registered read. Valid
// bits cleared by reset make unwritten bars read as level zero.
// ----------------------------------------------------------------------------
module bgfb_level_store (
   input  logic                        clock,
   input  logic                        reset,
   input  bgfb_pkg::lvl_wr_type        wr,
   input  bgfb_pkg::lvl_rd_type        rd,
   output logic [bgfb_pkg::LevelW-1:0] rd_level
);
   import bgfb_pkg::*;

   logic [LevelW-1:0]  level_mem [NumBars];
   logic [NumBars-1:0] valid_ff;
   logic [LevelW-1:0]  mem_q_ff;
   logic               valid_q_ff;

   // Memory array: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         level_mem[wr.addr] <= wr.level;
      end
      if (rd.en) begin
         mem_q_ff   <= level_mem[rd.addr];
         valid_q_ff <= valid_ff[rd.addr];
      end
   end

   // Per-entry valid bits, cleared at once by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   // An entry never written reads as level zero.
   assign rd_level = valid_q_ff ? mem_q_ff : '0;

endmodule

FILE: hdl/bar_graph_frame_builder_top.sv
// Single-frame ops go through the send state and enter the output register once free.
// Refresh: each row frame takes four level reads, one read drain and one send, and the
// eight frames are bound by the single read port of the store.
// Set level writes the store; init sends one frame per cycle while the output drains.
// Reset is synchronous and clears the sequencer, the output register and all bar
// levels (valid bits), so every bar reads as zero afterward.
// ----------------------------------------------------------------------------
// Bar graph frame builder
// Keeps sixteen bar levels and builds 64-bit command frames for a chain of
// four LED matrix drivers: eight row frames per refresh, plus intensity,
// display test and start-up command frames.
// ----------------------------------------------------------------------------
module bar_graph_frame_builder_top (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // op[2:0], bar_index[6:3], amount[14:7], zero[15]
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // word_first, word_second, word_third, word_fourth
   output logic [1:0]  rsp_tuser,  // frame_valid[0], bad_value[1]
   output logic        rsp_tlast
);
   import bgfb_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_DRAIN, ST_SEND} state_type;
   typedef enum logic [1:0] {MODE_REFRESH, MODE_INIT, MODE_SINGLE} mode_type;

   // Request fields.
   logic [OpW-1:0]     req_op;
   logic [BarIdxW-1:0] req_bar_index;
   logic [AmountW-1:0] req_amount;
   logic               accept;
   logic               out_free;

   assign req_op        = req_tdata[2:0];
   assign req_bar_index = req_tdata[6:3];
   assign req_amount    = req_tdata[14:7];

   // Sequencer and frame registers.
   state_type         state_ff, state_in;
   mode_type          mode_ff, mode_in;
   logic [2:0]        row_ff, row_in;
   logic [1:0]        slot_ff, slot_in;
   logic [1:0]        step_ff, step_in;
   logic              cap_valid_ff, cap_valid_in;
   logic [1:0]        cap_slot_ff, cap_slot_in;
   logic [WordW-1:0]  pend_word_ff [4];
   logic [WordW-1:0]  pend_word_in [4];
   logic              pend_frame_ff, pend_frame_in;
   logic              pend_bad_ff, pend_bad_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [WordW-1:0]  rsp_word_ff [4];
   logic [WordW-1:0]  rsp_word_in [4];
   logic              rsp_frame_ff, rsp_frame_in;
   logic              rsp_bad_ff, rsp_bad_in;
   logic              rsp_last_ff, rsp_last_in;

   // Level store interface.
   lvl_wr_type        lvl_wr;
   lvl_rd_type        lvl_rd;
   logic [LevelW-1:0] rd_level;
   logic [WordW-1:0]  intensity_word;
   logic [3:0]        row_num;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // A set_level request writes the store directly, saturated at full scale.
   assign lvl_wr.en    = accept && (req_op == OP_SET_LEVEL);
   assign lvl_wr.addr  = req_bar_index;
   assign lvl_wr.level = (req_amount > 8'(MAX_LEVEL)) ? MAX_LEVEL : req_amount[LevelW-1:0];

   // One level read per fetch cycle.
   assign lvl_rd.en   = (state_ff == ST_FETCH);
   assign lvl_rd.addr = slot_bar(row_ff, slot_ff);

   bgfb_level_store u_level_store (
      .clock    (clock),
      .reset    (reset),
      .wr       (lvl_wr),
      .rd       (lvl_rd),
      .rd_level (rd_level)
   );

   assign intensity_word = {REG_INTENSITY, 3'b000, req_amount[3:0], 1'b1};
   assign row_num        = 4'(row_ff) + 4'd1;

   // Next-state and datapath logic.
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      row_in        = row_ff;
      slot_in       = slot_ff;
      step_in       = step_ff;
      pend_word_in  = pend_word_ff;
      pend_frame_in = pend_frame_ff;
      pend_bad_in   = pend_bad_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_word_in   = rsp_word_ff;
      rsp_frame_in  = rsp_frame_ff;
      rsp_bad_in    = rsp_bad_ff;
      rsp_last_in   = rsp_last_ff;
      cap_valid_in  = (state_ff == ST_FETCH);
      cap_slot_in   = slot_ff;

      // Level read returned: place its byte, prefixed with the row number.
      if (cap_valid_ff) begin
         pend_word_in[cap_slot_ff] = {4'b0000, row_num, slot_byte(cap_slot_ff, rd_level)};
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_REFRESH: begin
                     mode_in       = MODE_REFRESH;
                     row_in        = '0;
                     slot_in       = '0;
                     pend_frame_in = 1'b1;
                     pend_bad_in   = 1'b0;
                     state_in      = ST_FETCH;
                  end
                  OP_SET_INTENSITY: begin
                     mode_in  = MODE_SINGLE;
                     state_in = ST_SEND;
                     if (req_amount > MAX_INTENSITY) begin
                        pend_word_in  = '{4{16'h0000}};
                        pend_frame_in = 1'b0;
                        pend_bad_in   = 1'b1;
                     end else begin
                        pend_word_in  = '{4{intensity_word}};
                        pend_frame_in = 1'b1;
                        pend_bad_in   = 1'b0;
                     end
                  end
                  OP_TEST_ON: begin
                     mode_in       = MODE_SINGLE;
                     pend_word_in  = '{4{CMD_TEST_ON}};
                     pend_frame_in = 1'b1;
                     pend_bad_in   = 1'b0;
                     state_in      = ST_SEND;
                  end
                  OP_TEST_OFF: begin
                     mode_in       = MODE_SINGLE;
                     pend_word_in  = '{4{CMD_TEST_OFF}};
                     pend_frame_in = 1'b1;
                     pend_bad_in   = 1'b0;
                     state_in      = ST_SEND;
                  end
                  OP_INIT: begin
                     mode_in       = MODE_INIT;
                     step_in       = '0;
                     pend_word_in  = '{4{INIT_SEQ[0]}};
                     pend_frame_in = 1'b1;
                     pend_bad_in   = 1'b0;
                     state_in      = ST_SEND;
                  end
                  default: begin
                     // Set level is handled by the store write; unused codes do nothing.
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_FETCH: begin
            slot_in = slot_ff + 2'd1;
            if (slot_ff == 2'd3) begin
               state_in = ST_DRAIN;
            end
         end

         ST_DRAIN: begin
            // The last read of the row lands this cycle.
            state_in = ST_SEND;
         end

         ST_SEND: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_word_in   = pend_word_ff;
               rsp_frame_in  = pend_frame_ff;
               rsp_bad_in    = pend_bad_ff;
               unique case (mode_ff)
                  MODE_REFRESH: begin
                     rsp_last_in = (row_ff == 3'd7);
                     if (row_ff == 3'd7) begin
                        state_in = ST_IDLE;
                     end else begin
                        row_in   = row_ff + 3'd1;
                        slot_in  = '0;
                        state_in = ST_FETCH;
                     end
                  end
                  MODE_INIT: begin
                     rsp_last_in = (step_ff == 2'd3);
                     if (step_ff == 2'd3) begin
                        state_in = ST_IDLE;
                     end else begin
                        step_in      = step_ff + 2'd1;
                        pend_word_in = '{4{INIT_SEQ[step_ff + 2'd1]}};
                     end
                  end
                  default: begin
                     rsp_last_in = 1'b1;
                     state_in    = ST_IDLE;
                  end
               endcase
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= MODE_SINGLE;
         row_ff        <= '0;
         slot_ff       <= '0;
         step_ff       <= '0;
         cap_valid_ff  <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         row_ff        <= row_in;
         slot_ff       <= slot_in;
         step_ff       <= step_in;
         cap_valid_ff  <= cap_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      cap_slot_ff   <= cap_slot_in;
      pend_word_ff  <= pend_word_in;
      pend_frame_ff <= pend_frame_in;
      pend_bad_ff   <= pend_bad_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_bad_ff    <= rsp_bad_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Result channel outputs.
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {rsp_word_ff[3], rsp_word_ff[2], rsp_word_ff[1], rsp_word_ff[0]};
   assign rsp_tuser  = {rsp_bad_ff, rsp_frame_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: tb/tb_bar_graph_frame_builder_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bar graph frame builder testbench
// Drives random and directed requests with random gaps and back-pressure, keeps
// its own copy of the bar levels, and compares every result frame against the
// frames predicted for the accepted requests, in order.
// ----------------------------------------------------------------------------
module tb_bar_graph_frame_builder_top;
   import bgfb_pkg::*;

   // Op codes that the block must ignore.
   localparam logic [OpW-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OpW-1:0] OP_SPARE_7 = 3'd7;

   // Long receiver hold-off, and the result count at which it starts.
   localparam int HoldCycles  = 300;
   localparam int HoldAtCount = 60;
   // Settle time after the last frame, well above one refresh.
   localparam int DrainCycles = 100;

   typedef struct packed {
      logic [WordW-1:0] w_first;
      logic [WordW-1:0] w_second;
      logic [WordW-1:0] w_third;
      logic [WordW-1:0] w_fourth;
      logic             frame_valid;
      logic             bad_value;
      logic             last;
   } frame_type;

   // Tracks the bar levels and the frames that are still owed by the block.
   class bar_frame_tracker;
      logic [LevelW-1:0] bar_level [NumBars];
      frame_type         owed_frames [$];
      int                mismatches;

      function new();
         foreach (bar_level[i]) bar_level[i] = '0;
         mismatches = 0;
      endfunction

      // Thermometer mask: the low "lvl" bits set, all sixteen at full level.
      function logic [15:0] level_mask(logic [LevelW-1:0] lvl);
         if (lvl >= MAX_LEVEL) return 16'hFFFF;
         return (16'd1 << lvl) - 16'd1;
      endfunction

      function logic [7:0] mirror(logic [7:0] b);
         logic [7:0] m;
         for (int i = 0; i < 8; i++) m[i] = b[7-i];
         return m;
      endfunction

      function void owe(logic [WordW-1:0] w1, logic [WordW-1:0] w2,
                        logic [WordW-1:0] w3, logic [WordW-1:0] w4,
                        logic ok, logic bad, logic fin);
         frame_type f;
         f = '{w1, w2, w3, w4, ok, bad, fin};
         owed_frames.push_back(f);
      endfunction

      // Apply one accepted request and queue the frames it causes.
      function void note_request(logic [OpW-1:0] op, logic [BarIdxW-1:0] idx,
                                 logic [AmountW-1:0] amt);
         logic [7:0]       row;
         logic [WordW-1:0] w;
         logic [15:0]      m1, m2, m3, m4;
         case (op)
            OP_SET_LEVEL: begin
               bar_level[idx] = (amt > MAX_LEVEL) ? MAX_LEVEL : amt[LevelW-1:0];
            end
            OP_REFRESH: begin
               for (int k = 0; k < 8; k++) begin
                  row = 8'(k + 1);
                  m1 = level_mask(bar_level[7 - k]);
                  m2 = level_mask(bar_level[15 - k]);
                  m3 = level_mask(bar_level[k + 8]);
                  m4 = level_mask(bar_level[k]);
                  owe({row, m1[15:8]}, {row, m2[15:8]},
                      {row, mirror(m3[7:0])}, {row, mirror(m4[7:0])},
                      1'b1, 1'b0, k == 7);
               end
            end
            OP_SET_INTENSITY: begin
               if (amt > MAX_INTENSITY) begin
                  owe('0, '0, '0, '0, 1'b0, 1'b1, 1'b1);
               end else begin
                  w = {REG_INTENSITY, 8'h00} + 16'(amt) * 16'd2 + 16'd1;
                  owe(w, w, w, w, 1'b1, 1'b0, 1'b1);
               end
            end
            OP_TEST_ON: begin
               owe(CMD_TEST_ON, CMD_TEST_ON, CMD_TEST_ON, CMD_TEST_ON, 1'b1, 1'b0, 1'b1);
            end
            OP_TEST_OFF: begin
               owe(CMD_TEST_OFF, CMD_TEST_OFF, CMD_TEST_OFF, CMD_TEST_OFF,
                   1'b1, 1'b0, 1'b1);
            end
            OP_INIT: begin
               for (int k = 0; k < 4; k++) begin
                  owe(INIT_SEQ[k], INIT_SEQ[k], INIT_SEQ[k], INIT_SEQ[k],
                      1'b1, 1'b0, k == 3);
               end
            end
            default: begin
            end
         endcase
      endfunction

      // Compare one accepted result with the oldest owed frame.
      function void check_frame(logic [63:0] data, logic [1:0] user, logic fin);
         frame_type got, want;
         got = '{data[15:0], data[31:16], data[47:32], data[63:48],
                 user[0], user[1], fin};
         if (owed_frames.size() == 0) begin
            if (mismatches < 10)
               $display("%0t: unexpected frame %h", $realtime, got);
            mismatches++;
         end else begin
            want = owed_frames.pop_front();
            if (got.w_first !== want.w_first || got.w_second !== want.w_second ||
                got.w_third !== want.w_third || got.w_fourth !== want.w_fourth ||
                got.frame_valid !== want.frame_valid ||
                got.bad_value !== want.bad_value || got.last !== want.last) begin
               if (mismatches < 10)
                  $display("%0t: frame mismatch expected %h actual %h",
                           $realtime, want, got);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   bar_frame_tracker tracker = new();
   int               frames_taken = 0;

   bar_graph_frame_builder_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watch both channels at each rising edge.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         tracker.note_request(req_tdata[2:0], req_tdata[6:3], req_tdata[14:7]);
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.check_frame(rsp_tdata, rsp_tuser, rsp_tlast);
         frames_taken++;
      end
   end

   // Offer one request after a random gap and hold it until it is taken.
   task automatic send_request(logic [OpW-1:0] op, logic [BarIdxW-1:0] idx,
                               logic [AmountW-1:0] amt);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, amt, idx, op};
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   // Stop offering until the block has delivered everything owed.
   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.owed_frames.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_request();
      int                 pick;
      logic [OpW-1:0]     op;
      logic [AmountW-1:0] amt;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         op  = OP_SET_LEVEL;
         amt = ($urandom_range(0, 3) != 0) ? AmountW'($urandom_range(0, 16))
                                           : AmountW'($urandom_range(0, 255));
      end else if (pick < 65) begin
         op  = OP_REFRESH;
         amt = AmountW'($urandom_range(0, 255));
      end else if (pick < 80) begin
         op  = OP_SET_INTENSITY;
         amt = ($urandom_range(0, 4) < 3) ? AmountW'($urandom_range(0, 15))
                                          : AmountW'($urandom_range(0, 255));
      end else if (pick < 86) begin
         op  = OP_TEST_ON;
         amt = AmountW'($urandom_range(0, 255));
      end else if (pick < 92) begin
         op  = OP_TEST_OFF;
         amt = AmountW'($urandom_range(0, 255));
      end else if (pick < 97) begin
         op  = OP_INIT;
         amt = AmountW'($urandom_range(0, 255));
      end else begin
         op  = $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
         amt = AmountW'($urandom_range(0, 255));
      end
      send_request(op, BarIdxW'($urandom_range(0, 15)), amt);
   endtask

   // Receiver: random stall before each frame, plus one long hold-off.
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = (frames_taken == HoldAtCount) ? HoldCycles : $urandom_range(0, 3);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // Main sequence.
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: refresh from reset, level extremes, every op, spare codes.
      send_request(OP_REFRESH, 4'd0, 8'd0);
      send_request(OP_SET_LEVEL, 4'd0, 8'd16);
      send_request(OP_SET_LEVEL, 4'd15, 8'd255);
      send_request(OP_SET_LEVEL, 4'd7, 8'd17);
      send_request(OP_SET_LEVEL, 4'd8, 8'd1);
      send_request(OP_SET_LEVEL, 4'd3, 8'd8);
      send_request(OP_SET_LEVEL, 4'd12, 8'd9);
      send_request(OP_REFRESH, 4'd15, 8'd255);
      send_request(OP_SET_INTENSITY, 4'd0, 8'd0);
      send_request(OP_SET_INTENSITY, 4'd0, 8'd15);
      send_request(OP_SET_INTENSITY, 4'd0, 8'd16);
      send_request(OP_SET_INTENSITY, 4'd15, 8'd255);
      send_request(OP_TEST_ON, 4'd0, 8'd0);
      send_request(OP_TEST_OFF, 4'd15, 8'd255);
      send_request(OP_INIT, 4'd5, 8'd170);
      send_request(OP_SPARE_6, 4'd15, 8'd255);
      send_request(OP_SPARE_7, 4'd10, 8'd85);
      send_request(OP_SET_LEVEL, 4'd15, 8'd0);
      send_request(OP_REFRESH, 4'd0, 8'd0);

      // Random part, with two pauses that let the block drain completely.
      for (int i = 0; i < 251; i++) begin
         if (i == 90 || i == 180) pause_until_drained();
         send_random_request();
      end
      req_tvalid <= 1'b0;

      // Wait for the owed frames, then allow the block to settle.
      while (tracker.owed_frames.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.owed_frames.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog for a stuck handshake.
   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

endmodule

FILE: files.f
hdl/bgfb_pkg.sv
hdl/bgfb_level_store.sv
hdl/bar_graph_frame_builder_top.sv
tb/tb_bar_graph_frame_builder_top.sv
